/* sv/dll_pkg.sv */
// Shared types, token classes, scanner modes and the keyword table of the lexer.
package dll_pkg;

  // Field widths and saturation limits of positions and lengths
  localparam int unsigned LINE_W = 16;
  localparam int unsigned COL_W  = 12;
  localparam int unsigned LEN_W  = 12;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

  // Keyword table geometry
  localparam int unsigned KW_SLOTS = 32;
  localparam int unsigned KW_BYTES = 16;

  // Control characters that steer position counting
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_FF  = 8'h0C;

  typedef enum logic [5:0] {
    C_END, C_ERR, C_ID, C_LDEF, C_RDEF, C_INT, C_REAL, C_CHAR, C_STRING, C_BOOL,
    C_KBLOCK, C_KBOOL, C_KCONST, C_KELSE, C_KERROR, C_KFLOAT, C_KFUNCDEF, C_KINT,
    C_KNIL, C_KPREFUNC, C_KSIGNAL, C_KSTART, C_KTYPE, C_KIN, C_KOUT, C_KCHAR,
    C_KDATALIST, C_KPARLIST, C_KDELAYLIST, C_KTYPEDEF, C_KVALUE, C_DUP,
    C_ADD, C_SUB, C_MUL, C_DIV, C_IDIV, C_LEN, C_TRANS, C_Q, C_ANG, C_COLON,
    C_SEMI, C_COMMA, C_RPAR, C_RBRK, C_RBRC, C_LPAR, C_LBRK, C_LBRC, C_PARS,
    C_BRKS, C_BRCS, C_DOT, C_DDOT, C_NE, C_EQ, C_LE, C_GE, C_LT, C_GT,
    C_LASS, C_RASS
  } tok_cls_e;

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_NUM, M_MINUS, M_SLASH, M_LCOM, M_BCOM, M_STR_FIRST,
    M_STR_BODY, M_STR_ESC, M_CHR1, M_CHR2, M_LT, M_GT, M_EQ, M_BANG, M_DOT,
    M_LPAR, M_LBRK, M_LBRC
  } mode_e;

  // What the lookahead slot holds
  typedef enum logic [1:0] {
    HV_NONE = 2'd0,
    HV_ID   = 2'd1,
    HV_RASS = 2'd2
  } held_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_byte;
  } lex_in_t;

  typedef struct packed {
    logic [5:0]        token_class;
    logic [LINE_W-1:0] start_line;
    logic [COL_W-1:0]  start_column;
    logic [LEN_W-1:0]  token_length;
    logic [7:0]        char_value;
    logic              last;
  } lex_out_t;

  typedef struct packed {
    tok_cls_e          cls;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [LEN_W-1:0]  len;
    logic [7:0]        chv;
  } tok_t;

  // Tokens produced by one input beat, oldest first
  typedef struct packed {
    logic [1:0]         n;
    lex_out_t [2:0]     beat;
  } emit_t;

  typedef struct packed {
    tok_t       held;
    held_e      hv;
    logic [1:0] n;
    tok_t       e0;
    tok_t       e1;
  } pair_t;

  localparam logic [KW_BYTES*8-1:0] KW_STR [KW_SLOTS] = '{
    "block", "bool", "const", "dup", "else", "error", "false", "float",
    "funcdef", "int", "nil", "prefunc", "signal", "start", "true", "type",
    "in", "out", "char", "datalist", "parlist", "delaylist", "typedef", "value",
    '0, '0, '0, '0, '0, '0, '0, '0
  };

  localparam logic [4:0] KW_LEN [KW_SLOTS] = '{
    5'd5, 5'd4, 5'd5, 5'd3, 5'd4, 5'd5, 5'd5, 5'd5,
    5'd7, 5'd3, 5'd3, 5'd7, 5'd6, 5'd5, 5'd4, 5'd4,
    5'd2, 5'd3, 5'd4, 5'd8, 5'd7, 5'd9, 5'd7, 5'd5,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
  };

  localparam tok_cls_e KW_CLS [KW_SLOTS] = '{
    C_KBLOCK, C_KBOOL, C_KCONST, C_DUP, C_KELSE, C_KERROR, C_BOOL, C_KFLOAT,
    C_KFUNCDEF, C_KINT, C_KNIL, C_KPREFUNC, C_KSIGNAL, C_KSTART, C_BOOL, C_KTYPE,
    C_KIN, C_KOUT, C_KCHAR, C_KDATALIST, C_KPARLIST, C_KDELAYLIST, C_KTYPEDEF,
    C_KVALUE, C_ID, C_ID, C_ID, C_ID, C_ID, C_ID, C_ID, C_ID
  };

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic lex_out_t to_beat(tok_t t, logic last);
    lex_out_t b;
    b.token_class  = t.cls;
    b.start_line   = t.line;
    b.start_column = t.col;
    b.token_length = t.len;
    b.char_value   = t.chv;
    b.last         = last;
    return b;
  endfunction

  // Lookahead pairing: ident followed by << and >> followed by ident
  function automatic pair_t pair_in(tok_t held, held_e hv, tok_t t);
    pair_t p;
    tok_t  h;
    p.n    = 2'd0;
    p.e0   = t;
    p.e1   = t;
    p.held = held;
    p.hv   = HV_NONE;
    h      = held;
    if (hv == HV_ID) begin
      if (t.cls == C_LASS) begin
        h.cls = C_LDEF;
        p.e0  = h;
        p.n   = 2'd1;
        return p;
      end
      p.e0 = held;
      p.n  = 2'd1;
    end else if (hv == HV_RASS) begin
      if (t.cls == C_ID) begin
        h     = t;
        h.cls = C_RDEF;
        p.e0  = h;
        p.n   = 2'd1;
        return p;
      end
      p.e0 = held;
      p.n  = 2'd1;
    end
    if (t.cls == C_ID) begin
      p.held = t;
      p.hv   = HV_ID;
    end else if (t.cls == C_RASS) begin
      p.held = t;
      p.hv   = HV_RASS;
    end else if (p.n == 2'd0) begin
      p.e0 = t;
      p.n  = 2'd1;
    end else begin
      p.e1 = t;
      p.n  = 2'd2;
    end
    return p;
  endfunction

endpackage

/* sv/dataflow_language_lexer.sv */
// Top level of the streaming dataflow-language lexer.
// One source byte (or an end-of-input mark) is taken per beat; every beat is
// scanned in the same cycle it is accepted, so a new byte can follow each
// cycle. A beat yields zero to three token beats (a held identifier or >>
// released by the lookahead, a closed token, a one-character token, or END),
// which wait in an eight-entry result queue; the input is ready whenever the
// queue has room for three more beats, so the sustained rate is one byte per
// cycle as long as tokens drain at least as fast as they are produced. The
// keyword compare runs over the whole table in parallel within that cycle.
module dataflow_language_lexer import dll_pkg::*; #(
  parameter int unsigned KEYWORD_CHARS = 9,
  parameter int unsigned KEYWORD_COUNT = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lex_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lex_out_t out_data_o
);

  emit_t emit;
  logic  space;
  logic  step;

  assign in_ready_o = space;
  assign step       = in_valid_i && space;

  dll_core #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .KEYWORD_COUNT (KEYWORD_COUNT)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .in_data_i (in_data_i),
    .emit_o    (emit)
  );

  dll_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* sv/dll_core.sv */
// Scanner state and the combinational next-state and token logic for one byte.
module dll_core import dll_pkg::*; #(
  parameter int unsigned KEYWORD_CHARS = 9,
  parameter int unsigned KEYWORD_COUNT = 24
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  lex_in_t in_data_i,
  output emit_t   emit_o
);

  localparam int unsigned IDXW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;

  mode_e             mode_q, mode_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic              nfe_q, nfe_d, nfp_q, nfp_d;
  logic [LINE_W-1:0] line_q, line_d, tsl_q, tsl_d;
  logic [COL_W-1:0]  col_q, col_d, tsc_q, tsc_d;
  logic [7:0]        prev_q, prev_d;
  held_e             hv_q, hv_d;
  tok_t              held_q, held_d;
  logic [7:0]        buf_q [KEYWORD_CHARS];

  logic              wr_en;
  logic [IDXW-1:0]   wr_idx;
  logic [7:0]        c;
  logic [LEN_W-1:0]  grown;
  tok_cls_e          kw_cls;
  logic              fin1_v, fin2_v, rep;
  tok_cls_e          f1_cls;
  logic [7:0]        f1_chv;
  tok_t              fin1, fin2;
  pair_t             p1, p2;
  tok_t              em [3];
  logic [1:0]        ne;

  assign c     = in_data_i.char_byte;
  assign grown = (cnt_q != LEN_MAX) ? cnt_q + LEN_W'(1) : cnt_q;

  // Keyword lookup, all table entries in parallel
  always_comb begin
    logic hit;
    kw_cls = C_ID;
    for (int i = KW_SLOTS - 1; i >= 0; i--) begin
      hit = (i < KEYWORD_COUNT) && (LEN_W'(KW_LEN[i]) == cnt_q)
            && (cnt_q <= LEN_W'(KEYWORD_CHARS));
      for (int k = 0; k < KW_BYTES; k++) begin
        if (k < int'(KW_LEN[i])) begin
          if (k < KEYWORD_CHARS) begin
            if (buf_q[k] != KW_STR[i][(int'(KW_LEN[i]) - 1 - k) * 8 +: 8]) hit = 1'b0;
          end else begin
            hit = 1'b0;
          end
        end
      end
      if (hit) kw_cls = KW_CLS[i];
    end
  end

  // Next state and tokens for the accepted beat
  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    nfe_d  = nfe_q;
    nfp_d  = nfp_q;
    line_d = line_q;
    col_d  = col_q;
    tsl_d  = tsl_q;
    tsc_d  = tsc_q;
    prev_d = prev_q;
    wr_en  = 1'b0;
    wr_idx = '0;
    fin1_v = 1'b0;
    fin2_v = 1'b0;
    rep    = 1'b0;
    f1_cls = C_ERR;
    f1_chv = 8'd0;
    fin1   = '0;
    fin2   = '0;

    if (step_i && in_data_i.kind) begin
      // end of input: close the open token, then END
      fin1_v = 1'b1;
      case (mode_q)
        M_IDENT: f1_cls = kw_cls;
        M_NUM:   f1_cls = (nfe_q || nfp_q) ? C_REAL : C_INT;
        M_MINUS: f1_cls = C_SUB;
        M_SLASH: f1_cls = C_DIV;
        M_LT:    f1_cls = C_LT;
        M_GT:    f1_cls = C_GT;
        M_EQ:    f1_cls = C_EQ;
        M_DOT:   f1_cls = C_DOT;
        M_LPAR:  f1_cls = C_LPAR;
        M_LBRK:  f1_cls = C_LBRK;
        M_LBRC:  f1_cls = C_LBRC;
        M_BANG, M_BCOM, M_STR_FIRST, M_STR_BODY, M_STR_ESC, M_CHR1, M_CHR2:
          f1_cls = C_ERR;
        default: fin1_v = 1'b0;
      endcase
      fin1   = '{cls: f1_cls, line: tsl_q, col: tsc_q, len: cnt_q, chv: 8'd0};
      fin2_v = 1'b1;
      fin2   = '{cls: C_END, line: line_q, col: col_q, len: '0, chv: 8'd0};
      mode_d = M_IDLE;
      cnt_d  = '0;
      nfe_d  = 1'b0;
      nfp_d  = 1'b0;
      line_d = LINE_W'(1);
      col_d  = '0;
      tsl_d  = '0;
      tsc_d  = '0;
      prev_d = 8'd0;
    end else if (step_i) begin
      // position of this character
      if (c == CH_LF) begin
        if (line_q != LINE_MAX) line_d = line_q + LINE_W'(1);
        col_d = '0;
      end else if (c != CH_FF && c != CH_TAB) begin
        if (col_q != COL_MAX) col_d = col_q + COL_W'(1);
      end

      // first pass: continue the open token
      case (mode_q)
        M_IDENT: begin
          if (is_letter(c) || is_digit(c) || (c == "." && prev_q != ".")) begin
            if (cnt_q < LEN_W'(KEYWORD_CHARS)) begin
              wr_en  = 1'b1;
              wr_idx = cnt_q[IDXW-1:0];
            end
            cnt_d  = grown;
            prev_d = c;
          end else begin
            fin1_v = 1'b1; f1_cls = kw_cls; rep = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(c)) begin
            cnt_d = grown; prev_d = c;
          end else if (c == "e" || c == "E") begin
            if (!nfe_q && is_digit(prev_q)) begin
              nfe_d = 1'b1; cnt_d = grown; prev_d = c;
            end else begin
              fin1_v = 1'b1; f1_cls = C_ERR; rep = 1'b1;
            end
          end else if (is_letter(c)) begin
            fin1_v = 1'b1; f1_cls = C_ERR; rep = 1'b1;
          end else if (c == ".") begin
            if (nfe_q || nfp_q) begin
              fin1_v = 1'b1; f1_cls = C_ERR; rep = 1'b1;
            end else begin
              nfp_d = 1'b1; cnt_d = grown; prev_d = c;
            end
          end else if (c == "+" || c == "-") begin
            if (prev_q == "e" || prev_q == "E") begin
              cnt_d = grown; prev_d = c;
            end else begin
              fin1_v = 1'b1; f1_cls = C_ERR; rep = 1'b1;
            end
          end else begin
            fin1_v = 1'b1; f1_cls = (nfe_q || nfp_q) ? C_REAL : C_INT; rep = 1'b1;
          end
        end
        M_MINUS: begin
          if (is_digit(c)) begin
            mode_d = M_NUM; nfe_d = 1'b0; nfp_d = 1'b0; cnt_d = grown; prev_d = c;
          end else if (c == ".") begin
            mode_d = M_NUM; nfe_d = 1'b0; nfp_d = 1'b1; cnt_d = grown; prev_d = c;
          end else begin
            fin1_v = 1'b1; f1_cls = C_SUB; rep = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") begin
            mode_d = M_LCOM;
          end else if (c == "*") begin
            mode_d = M_BCOM; cnt_d = grown; prev_d = 8'd0;
          end else begin
            fin1_v = 1'b1; f1_cls = C_DIV; rep = 1'b1;
          end
        end
        M_LCOM: begin
          if (c == CH_LF) mode_d = M_IDLE;
        end
        M_BCOM: begin
          cnt_d = grown;
          if (prev_q == "*" && c == "/") mode_d = M_IDLE;
          else prev_d = c;
        end
        M_STR_FIRST, M_STR_BODY: begin
          if (mode_q == M_STR_BODY && c == "\"") begin
            cnt_d = grown; fin1_v = 1'b1; f1_cls = C_STRING;
          end else if (c == CH_LF) begin
            fin1_v = 1'b1; f1_cls = C_ERR; rep = 1'b1;
          end else begin
            cnt_d  = grown;
            mode_d = (c == "\\") ? M_STR_ESC : M_STR_BODY;
          end
        end
        M_STR_ESC: begin
          cnt_d = grown; mode_d = M_STR_BODY;
        end
        M_CHR1: begin
          cnt_d = grown; prev_d = c; mode_d = M_CHR2;
        end
        M_CHR2: begin
          if (c == "'") begin
            cnt_d = grown; fin1_v = 1'b1; f1_cls = C_CHAR; f1_chv = prev_q;
          end else begin
            fin1_v = 1'b1; f1_cls = C_ERR; rep = 1'b1;
          end
        end
        M_LT: begin
          fin1_v = 1'b1;
          if (c == "<")      begin cnt_d = grown; f1_cls = C_LASS; end
          else if (c == "=") begin cnt_d = grown; f1_cls = C_LE; end
          else               begin f1_cls = C_LT; rep = 1'b1; end
        end
        M_GT: begin
          fin1_v = 1'b1;
          if (c == ">")      begin cnt_d = grown; f1_cls = C_RASS; end
          else if (c == "=") begin cnt_d = grown; f1_cls = C_GE; end
          else               begin f1_cls = C_GT; rep = 1'b1; end
        end
        M_EQ: begin
          fin1_v = 1'b1;
          if (c == "<")      begin cnt_d = grown; f1_cls = C_LE; end
          else if (c == ">") begin cnt_d = grown; f1_cls = C_GE; end
          else               begin f1_cls = C_EQ; rep = 1'b1; end
        end
        M_BANG: begin
          fin1_v = 1'b1;
          if (c == "=") begin cnt_d = grown; f1_cls = C_NE; end
          else          begin f1_cls = C_ERR; rep = 1'b1; end
        end
        M_DOT: begin
          fin1_v = 1'b1;
          if (c == ".") begin cnt_d = grown; f1_cls = C_DDOT; end
          else          begin f1_cls = C_DOT; rep = 1'b1; end
        end
        M_LPAR: begin
          fin1_v = 1'b1;
          if (c == ")") begin cnt_d = grown; f1_cls = C_PARS; end
          else          begin f1_cls = C_LPAR; rep = 1'b1; end
        end
        M_LBRK: begin
          fin1_v = 1'b1;
          if (c == "]") begin cnt_d = grown; f1_cls = C_BRKS; end
          else          begin f1_cls = C_LBRK; rep = 1'b1; end
        end
        M_LBRC: begin
          fin1_v = 1'b1;
          if (c == "}") begin cnt_d = grown; f1_cls = C_BRCS; end
          else          begin f1_cls = C_LBRC; rep = 1'b1; end
        end
        default: ;
      endcase
      if (fin1_v) mode_d = M_IDLE;
      fin1 = '{cls: f1_cls, line: tsl_q, col: tsc_q, len: cnt_d, chv: f1_chv};

      // second pass: the character opens a new token
      if (mode_q == M_IDLE || rep) begin
        tsl_d  = line_d;
        tsc_d  = col_d;
        mode_d = M_IDLE;
        fin2   = '{cls: C_ADD, line: line_d, col: col_d, len: LEN_W'(1), chv: 8'd0};
        if (is_letter(c)) begin
          mode_d = M_IDENT; cnt_d = LEN_W'(1); wr_en = 1'b1; wr_idx = '0; prev_d = c;
        end else if (is_digit(c)) begin
          mode_d = M_NUM; cnt_d = LEN_W'(1); nfe_d = 1'b0; nfp_d = 1'b0; prev_d = c;
        end else begin
          cnt_d  = LEN_W'(1);
          fin2_v = 1'b1;
          case (c)
            "\"": begin mode_d = M_STR_FIRST; fin2_v = 1'b0; end
            "'":  begin mode_d = M_CHR1;      fin2_v = 1'b0; end
            "-":  begin mode_d = M_MINUS;     fin2_v = 1'b0; end
            "/":  begin mode_d = M_SLASH;     fin2_v = 1'b0; end
            "<":  begin mode_d = M_LT;        fin2_v = 1'b0; end
            ">":  begin mode_d = M_GT;        fin2_v = 1'b0; end
            "=":  begin mode_d = M_EQ;        fin2_v = 1'b0; end
            "!":  begin mode_d = M_BANG;      fin2_v = 1'b0; end
            ".":  begin mode_d = M_DOT;       fin2_v = 1'b0; end
            "(":  begin mode_d = M_LPAR;      fin2_v = 1'b0; end
            "[":  begin mode_d = M_LBRK;      fin2_v = 1'b0; end
            "{":  begin mode_d = M_LBRC;      fin2_v = 1'b0; end
            "+":  fin2.cls = C_ADD;
            "*":  fin2.cls = C_MUL;
            "%":  fin2.cls = C_IDIV;
            "|":  fin2.cls = C_LEN;
            "#":  fin2.cls = C_TRANS;
            "?":  fin2.cls = C_Q;
            "^":  fin2.cls = C_ANG;
            ":":  fin2.cls = C_COLON;
            ";":  fin2.cls = C_SEMI;
            ",":  fin2.cls = C_COMMA;
            ")":  fin2.cls = C_RPAR;
            "]":  fin2.cls = C_RBRK;
            "}":  fin2.cls = C_RBRC;
            default: begin
              // skipped character: nothing opens
              fin2_v = 1'b0;
              cnt_d  = (mode_q == M_IDLE) ? cnt_q : cnt_d;
              tsl_d  = (mode_q == M_IDLE) ? tsl_q : line_d;
              tsc_d  = (mode_q == M_IDLE) ? tsc_q : col_d;
            end
          endcase
        end
      end
    end
  end

  // Lookahead pairing of up to two finished tokens
  always_comb begin
    held_e hv_t;
    tok_t  held_t;
    hv_t   = hv_q;
    held_t = held_q;
    ne     = 2'd0;
    em[0]  = fin1;
    em[1]  = fin1;
    em[2]  = fin1;
    p1     = pair_in(held_t, hv_t, fin1);
    p2     = '0;
    if (fin1_v) begin
      hv_t   = p1.hv;
      held_t = p1.held;
      if (p1.n != 2'd0) begin em[ne] = p1.e0; ne = ne + 2'd1; end
      if (p1.n == 2'd2) begin em[ne] = p1.e1; ne = ne + 2'd1; end
    end
    p2 = pair_in(held_t, hv_t, fin2);
    if (fin2_v) begin
      hv_t   = p2.hv;
      held_t = p2.held;
      if (p2.n != 2'd0 && ne != 2'd3) begin em[ne] = p2.e0; ne = ne + 2'd1; end
      if (p2.n == 2'd2 && ne != 2'd3) begin em[ne] = p2.e1; ne = ne + 2'd1; end
    end
    hv_d   = hv_t;
    held_d = held_t;
    if (step_i && in_data_i.kind) begin
      hv_d   = HV_NONE;
      held_d = '0;
    end
  end

  // Result beats, last flag on the final one
  always_comb begin
    emit_o.n = step_i ? ne : 2'd0;
    for (int i = 0; i < 3; i++) begin
      emit_o.beat[i] = to_beat(em[i], 2'(i) == ne - 2'd1);
    end
  end

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cnt_q  <= '0;
      nfe_q  <= 1'b0;
      nfp_q  <= 1'b0;
      line_q <= LINE_W'(1);
      col_q  <= '0;
      tsl_q  <= '0;
      tsc_q  <= '0;
      prev_q <= 8'd0;
      hv_q   <= HV_NONE;
      held_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      nfe_q  <= nfe_d;
      nfp_q  <= nfp_d;
      line_q <= line_d;
      col_q  <= col_d;
      tsl_q  <= tsl_d;
      tsc_q  <= tsc_d;
      prev_q <= prev_d;
      hv_q   <= hv_d;
      held_q <= held_d;
    end
  end

  // Identifier prefix for keyword matching
  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) buf_q[wr_idx] <= c;
  end

endmodule

/* sv/dll_fifo.sv */
// Result queue: takes up to three beats per cycle, hands out one per cycle while out_ready_i is high.
module dll_fifo import dll_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  emit_t    emit_i,
  output logic     space_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lex_out_t out_data_o
);

  localparam int unsigned DEPTH = 8;
  localparam int unsigned PW    = $clog2(DEPTH);

  lex_out_t        mem [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem[rd_q];
  // room for a worst-case beat triple
  assign space_o     = cnt_q <= (PW+1)'(DEPTH - 3);

  // Pointer and fill updates
  always_comb begin
    wr_d  = wr_q + PW'(emit_i.n);
    rd_d  = pop ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(emit_i.n) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < emit_i.n) mem[wr_q + PW'(i)] <= emit_i.beat[i];
    end
  end

endmodule
